FILE: rtl/ffrp_pkg.sv
// Shared types and constants for the flagged frame receive parser.
// Used by ffrp_parse and flagged_frame_receive_parser; no dependencies.
package ffrp_pkg;

   // Receive buffer length: the byte counter wraps here, and it sets the length limit.
   localparam int unsigned BufLen   = 256;
   localparam int unsigned CountW   = $clog2(BufLen);
   localparam int unsigned MaxLen   = BufLen - 4;
   localparam int unsigned LenW     = 16;

   // Register map: one 32-bit word per register, and paddr[2] selects the word.
   localparam int unsigned CsrAddrW = 3;
   localparam int unsigned CsrDataW = 32;
   localparam logic [0:0]  RegStartFlag = 1'b0;

   // Parser phases
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_START,
      PH_CKSM,
      PH_LEN,
      PH_BODY
   } phase_type;

   // One result beat as produced by the parser
   typedef struct packed {
      logic       valid;
      logic [7:0] body_byte;
      logic       frame_last;
   } result_type;

endpackage

FILE: rtl/ffrp_parse.sv
// Frame header parser and body byte stream for one received byte per beat.
// Depends on ffrp_pkg (phase_type, result_type, BufLen constants).
module ffrp_parse import ffrp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        beat,
   input  logic [7:0]  rx_byte,
   input  logic [7:0]  start_flag,
   output result_type  result
);

   phase_type          phase_ff, phase_in;
   logic [CountW-1:0]  byte_count_ff, byte_count_in;
   logic [7:0]         check_byte_ff, check_byte_in;
   logic [7:0]         length_high_ff, length_high_in;
   logic [LenW-1:0]    bytes_left_ff, bytes_left_in;

   logic [CountW:0]    count_sum;
   logic [CountW-1:0]  count_next;
   logic [LenW-1:0]    frame_len;
   logic               header_ok;

   // Running byte count, wraps at the buffer length
   assign count_sum  = {1'b0, byte_count_ff} + (CountW+1)'(1);
   assign count_next = (count_sum >= (CountW+1)'(BufLen)) ? '0 : count_sum[CountW-1:0];

   // Header check: checksum against flag ^ length bytes, length below the limit
   assign frame_len = {length_high_ff, rx_byte};
   assign header_ok = (check_byte_ff == (start_flag ^ length_high_ff ^ rx_byte)) &&
                      ({1'b0, frame_len} < (LenW+1)'(MaxLen));

   // Next state and result for the byte on rx_byte
   always_comb begin
      phase_in       = phase_ff;
      byte_count_in  = count_next;
      check_byte_in  = check_byte_ff;
      length_high_in = length_high_ff;
      bytes_left_in  = bytes_left_ff;
      result         = '0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (rx_byte == start_flag && count_next == CountW'(1)) begin
               phase_in = PH_START;
            end
         end
         PH_START: begin
            if (count_next == CountW'(2)) begin
               check_byte_in = rx_byte;
               phase_in      = PH_CKSM;
            end else begin
               phase_in      = PH_IDLE;
               bytes_left_in = '0;
               byte_count_in = '0;
            end
         end
         PH_CKSM: begin
            if (count_next == CountW'(3)) begin
               length_high_in = rx_byte;
               phase_in       = PH_LEN;
            end else begin
               phase_in      = PH_IDLE;
               bytes_left_in = '0;
               byte_count_in = '0;
            end
         end
         PH_LEN: begin
            if (count_next == CountW'(4)) begin
               bytes_left_in = frame_len;
               // a bad header stays here; the next byte drops back to idle
               if (header_ok) begin
                  phase_in = PH_BODY;
               end
            end else begin
               phase_in      = PH_IDLE;
               bytes_left_in = '0;
               byte_count_in = '0;
            end
         end
         PH_BODY: begin
            if (bytes_left_ff > LenW'(1)) begin
               bytes_left_in     = bytes_left_ff - LenW'(1);
               result.valid      = 1'b1;
               result.body_byte  = rx_byte;
               result.frame_last = 1'b0;
            end else begin
               // last body byte, or a zero-length frame that carries none
               result.valid      = (bytes_left_ff == LenW'(1));
               result.body_byte  = rx_byte;
               result.frame_last = 1'b1;
               phase_in          = PH_IDLE;
               bytes_left_in     = '0;
               byte_count_in     = '0;
            end
         end
         default: begin
            phase_in      = PH_IDLE;
            bytes_left_in = '0;
            byte_count_in = '0;
         end
      endcase

      if (!beat) begin
         result.valid = 1'b0;
      end
   end

   // State registers, updated on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         byte_count_ff  <= '0;
         check_byte_ff  <= '0;
         length_high_ff <= '0;
         bytes_left_ff  <= '0;
      end else if (beat) begin
         phase_ff       <= phase_in;
         byte_count_ff  <= byte_count_in;
         check_byte_ff  <= check_byte_in;
         length_high_ff <= length_high_in;
         bytes_left_ff  <= bytes_left_in;
      end
   end

endmodule

FILE: rtl/flagged_frame_receive_parser.sv
// Top level of the flagged frame receive parser: register port, parser, output buffer.
// Depends on ffrp_pkg and ffrp_parse.
//
// Takes one received byte per beat on req_ and streams the body bytes of good frames on
// rsp_, with rsp_frame_last marking the final body byte. A frame is start flag,
// checksum, 16-bit big-endian length, body. A byte is taken each cycle while req_ready
// is high: the parser updates its state in the same cycle, and its result enters a
// two-entry output buffer (output register plus skid register). req_ready falls only
// while both entries are full, so a byte is accepted in every cycle while rsp_ready
// stays high. The start flag value is the register at address 0.
module flagged_frame_receive_parser import ffrp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // byte input
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   // body byte output
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_body_byte,
   output logic                 rsp_frame_last,
   // register port
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [CsrAddrW-1:0]  csr_paddr,
   input  logic [CsrDataW-1:0]  csr_pwdata,
   output logic [CsrDataW-1:0]  csr_prdata,
   output logic                 csr_pready
);

   logic [7:0]  start_flag_ff;
   logic        flag_write;
   logic        req_beat;
   logic        rsp_beat;
   result_type  result;

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_last_ff, out_last_in;
   logic        skid_valid_ff, skid_valid_in;
   logic [7:0]  skid_byte_ff, skid_byte_in;
   logic        skid_last_ff, skid_last_in;

   // Register port
   assign csr_pready = 1'b1;
   assign flag_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == RegStartFlag);
   assign csr_prdata = (csr_paddr[2] == RegStartFlag) ?
                       {{(CsrDataW-8){1'b0}}, start_flag_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_flag_ff <= '0;
      end else if (flag_write) begin
         start_flag_ff <= csr_pwdata[7:0];
      end
   end

   // Handshakes
   assign req_ready = !skid_valid_ff;
   assign req_beat  = req_valid && req_ready;
   assign rsp_beat  = out_valid_ff && rsp_ready;

   ffrp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .beat       (req_beat),
      .rx_byte    (req_rx_byte),
      .start_flag (start_flag_ff),
      .result     (result)
   );

   // Output register with skid entry, in order
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      skid_valid_in = skid_valid_ff;
      skid_byte_in  = skid_byte_ff;
      skid_last_in  = skid_last_ff;
      if (!out_valid_ff || rsp_beat) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_byte_in   = skid_byte_ff;
            out_last_in   = skid_last_ff;
            skid_valid_in = result.valid;
            skid_byte_in  = result.body_byte;
            skid_last_in  = result.frame_last;
         end else begin
            out_valid_in  = result.valid;
            out_byte_in   = result.body_byte;
            out_last_in   = result.frame_last;
         end
      end else if (result.valid) begin
         skid_valid_in = 1'b1;
         skid_byte_in  = result.body_byte;
         skid_last_in  = result.frame_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      skid_byte_ff <= skid_byte_in;
      skid_last_ff <= skid_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_body_byte  = out_byte_ff;
   assign rsp_frame_last = out_last_ff;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking bench for flagged_frame_receive_parser: byte stream in, body bytes out.
// A local frame parser predicts each body beat; the start flag is reprogrammed over APB.
// Depends on ffrp_pkg and the RTL of the block only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ffrp_pkg::*;

   localparam int NumPhases     = 6;
   localparam int ItemsPerPhase = 70;

   // directed rows: predicted, typed as no result, typed body beat, or a flag write
   typedef enum logic [1:0] {RK_PRED, RK_NONE, RK_BODY, RK_FLAG} row_kind_type;
   typedef enum logic [1:0] {EP_GOOD, EP_BAD_CHECK, EP_TOO_LONG, EP_NOISE} episode_type;

   typedef struct packed {
      logic [7:0] body;
      logic       last;
   } body_beat_type;

   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   data;
      logic [7:0]   body;
      logic         last;
   } stim_row_type;

   localparam int NumRows = 24;
   localparam stim_row_type DirectedRows [NumRows] = '{
      // two-byte frame with reset flag 0x00, body at the byte extremes
      '{RK_NONE, 8'h00, 8'h00, 1'b0},
      '{RK_NONE, 8'h02, 8'h00, 1'b0},
      '{RK_NONE, 8'h00, 8'h00, 1'b0},
      '{RK_NONE, 8'h02, 8'h00, 1'b0},
      '{RK_BODY, 8'hFF, 8'hFF, 1'b0},
      '{RK_BODY, 8'h00, 8'h00, 1'b1},
      // zero length: header taken, next byte drops back to idle
      '{RK_NONE, 8'h00, 8'h00, 1'b0},
      '{RK_NONE, 8'h00, 8'h00, 1'b0},
      '{RK_NONE, 8'h00, 8'h00, 1'b0},
      '{RK_NONE, 8'h00, 8'h00, 1'b0},
      '{RK_NONE, 8'h5A, 8'h00, 1'b0},
      // bad header checksum, then one byte to return to idle
      '{RK_NONE, 8'h00, 8'h00, 1'b0},
      '{RK_NONE, 8'h33, 8'h00, 1'b0},
      '{RK_NONE, 8'h00, 8'h00, 1'b0},
      '{RK_NONE, 8'h01, 8'h00, 1'b0},
      '{RK_NONE, 8'h00, 8'h00, 1'b0},
      // flag changed between flag byte and length: checksum uses the new flag
      '{RK_NONE, 8'h00, 8'h00, 1'b0},
      '{RK_PRED, 8'h3D, 8'h00, 1'b0},
      '{RK_FLAG, 8'h3C, 8'h00, 1'b0},
      '{RK_PRED, 8'h00, 8'h00, 1'b0},
      '{RK_PRED, 8'h01, 8'h00, 1'b0},
      '{RK_PRED, 8'hC3, 8'h00, 1'b0},
      // flag seen as second byte after a clear is ignored
      '{RK_PRED, 8'h77, 8'h00, 1'b0},
      '{RK_PRED, 8'h3C, 8'h00, 1'b0}
   };

   logic                clock;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   logic [7:0]          req_rx_byte = 8'h00;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   logic [7:0]          rsp_body_byte;
   logic                rsp_frame_last;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CsrAddrW-1:0] csr_paddr   = '0;
   logic [CsrDataW-1:0] csr_pwdata  = '0;
   logic [CsrDataW-1:0] csr_prdata;
   logic                csr_pready;

   // parser mirror
   phase_type           rx_phase  = PH_IDLE;
   int unsigned         rx_count  = 0;
   logic [7:0]          rx_check  = 8'h00;
   logic [7:0]          rx_len_hi = 8'h00;
   logic [15:0]         rx_left   = 16'h0000;
   logic [7:0]          flag_reg  = 8'h00;

   body_beat_type       expected_beats[$];
   int                  mismatches  = 0;
   int                  bytes_in    = 0;
   int                  frame_bytes = 0;
   int                  beats_seen  = 0;
   int                  frames_seen = 0;
   int                  flag_writes = 0;
   bit                  sender_calm = 1'b0;

   flagged_frame_receive_parser u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_body_byte  (rsp_body_byte),
      .rsp_frame_last (rsp_frame_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Advance the parser mirror by one byte; returns 1 when a body beat comes out.
   function automatic bit parse_byte(input logic [7:0] b, output body_beat_type beat);
      logic [15:0] len;
      beat = '0;
      len  = {rx_len_hi, b};
      rx_count = rx_count + 1;
      if (rx_count >= BufLen) rx_count = 0;
      if (rx_phase == PH_IDLE) begin
         if (b == flag_reg && rx_count == 1) rx_phase = PH_START;
         return 1'b0;
      end
      if (rx_phase == PH_START && rx_count == 2) begin
         rx_check = b;
         rx_phase = PH_CKSM;
      end else if (rx_phase == PH_CKSM && rx_count == 3) begin
         rx_len_hi = b;
         rx_phase  = PH_LEN;
      end else if (rx_phase == PH_LEN && rx_count == 4) begin
         rx_left = len;
         // a bad header leaves the phase at length; the next byte clears it
         if (rx_check == (flag_reg ^ rx_len_hi ^ b) && len < MaxLen) rx_phase = PH_BODY;
      end else if (rx_phase == PH_BODY && rx_left > 1) begin
         rx_left = rx_left - 16'd1;
         beat = '{body: b, last: 1'b0};
         return 1'b1;
      end else if (rx_phase == PH_BODY && rx_left == 1) begin
         rx_phase = PH_IDLE;
         rx_left  = '0;
         rx_count = 0;
         beat = '{body: b, last: 1'b1};
         return 1'b1;
      end else begin
         rx_phase = PH_IDLE;
         rx_left  = '0;
         rx_count = 0;
      end
      return 1'b0;
   endfunction

   // Offer one byte after an optional gap, wait for the beat, then log what it should cause.
   task automatic send_byte(input logic [7:0] data, input row_kind_type kind,
                            input logic [7:0] body, input logic last);
      int            gap;
      bit            got;
      body_beat_type beat;
      gap = 0;
      if (!sender_calm) begin
         gap = $urandom_range(0, 99);
         if (gap < 70) gap = 0;
         else if (gap < 93) gap = $urandom_range(1, 3);
         else gap = $urandom_range(4, 24);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= data;
      do @(posedge clock); while (!req_ready);
      bytes_in++;
      got = parse_byte(data, beat);
      if (kind == RK_NONE) begin
         got = 1'b0;
      end else if (kind == RK_BODY) begin
         got  = 1'b1;
         beat = '{body: body, last: last};
      end
      if (got) expected_beats.push_back(beat);
   endtask

   // Stop offering bytes and wait until every expected beat has come out.
   task automatic drain_results(input int settle);
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // APB write of the start flag, then a read back of the same register.
   task automatic write_start_flag(input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {RegStartFlag, 2'b00};
      csr_pwdata  <= CsrDataW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      flag_reg = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[7:0] !== value) begin
         $error("start_flag: expected %02h, got %02h", value, csr_prdata[7:0]);
         mismatches++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      flag_writes++;
   endtask

   // Result side: compare each beat, and vary rsp_ready with calm and busy stretches.
   initial begin : result_check
      body_beat_type want;
      int            hold;
      int            segment;
      bit            calm;
      hold    = 0;
      segment = 0;
      calm    = 1'b1;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               $error("unexpected body beat: body_byte %02h frame_last %0b",
                      rsp_body_byte, rsp_frame_last);
               mismatches++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_body_byte !== want.body) begin
                  $error("body_byte: expected %02h, got %02h", want.body, rsp_body_byte);
                  mismatches++;
               end
               if (rsp_frame_last !== want.last) begin
                  $error("frame_last: expected %0b, got %0b", want.last, rsp_frame_last);
                  mismatches++;
               end
            end
            beats_seen++;
            if (rsp_frame_last === 1'b1) frames_seen++;
            // long hold-off so the output buffer fills and req_ready drops
            if (beats_seen % 128 == 64) hold = $urandom_range(48, 96);
         end
         if (segment == 0) begin
            calm    = ($urandom_range(0, 2) == 0);
            segment = $urandom_range(40, 200);
         end
         segment--;
         if (hold == 0 && !calm && $urandom_range(0, 99) < 3) hold = $urandom_range(4, 24);
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) < 75);
         end
      end
   end

   // Stimulus: directed table, then random frame episodes under several flag values.
   initial begin : stimulus
      stim_row_type row;
      episode_type  ep_kind;
      logic [7:0] frame_q[$];
      logic [7:0] fill;
      logic [7:0] new_flag;
      logic [7:0] hi;
      logic [7:0] lo;
      logic [15:0] len;
      int         ph;
      int         ep;
      int         i;
      int         pick;
      int         quota;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < NumRows; i++) begin
         row = DirectedRows[i];
         if (row.kind == RK_FLAG) begin
            drain_results(4);
            write_start_flag(row.data);
         end else begin
            send_byte(row.data, row.kind, row.body, row.last);
            frame_bytes++;
         end
      end

      for (ph = 0; ph < NumPhases; ph++) begin
         drain_results(4);
         case (ph)
            0: new_flag = 8'hFF;
            1: new_flag = 8'h00;
            3: new_flag = 8'h80;
            default: new_flag = 8'($urandom_range(0, 255));
         endcase
         write_start_flag(new_flag);
         // every byte sent counts toward the phase, fill bytes included
         quota = bytes_in + ItemsPerPhase;
         ep = 0;
         while (bytes_in < quota) begin
            // get back to idle with a cleared count, never hitting the flag in idle
            sender_calm = 1'b0;
            while (!(rx_phase == PH_IDLE && rx_count == 0)) begin
               do fill = 8'($urandom_range(0, 255));
               while (rx_phase == PH_IDLE && fill == flag_reg);
               send_byte(fill, RK_PRED, 8'h00, 1'b0);
            end

            sender_calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 70) ep_kind = EP_GOOD;
            else if (pick < 80) ep_kind = EP_BAD_CHECK;
            else if (pick < 90) ep_kind = EP_TOO_LONG;
            else ep_kind = EP_NOISE;

            pick = $urandom_range(0, 99);
            if (pick < 6) len = 16'd0;
            else if (pick < 14) len = 16'd1;
            else if (pick < 72) len = 16'($urandom_range(2, 10));
            else if (pick < 96) len = 16'($urandom_range(11, 40));
            else len = 16'($urandom_range(200, MaxLen - 1));
            if (ph == 0 && ep == 0) begin
               ep_kind = EP_GOOD;
               len = 16'(MaxLen - 1);
            end
            if (ep_kind == EP_BAD_CHECK) len = 16'($urandom_range(0, 20));
            hi = len[15:8];
            lo = len[7:0];
            if (ep_kind == EP_TOO_LONG) begin
               hi = 8'($urandom_range(0, 255));
               lo = (hi == 8'h00) ? 8'($urandom_range(MaxLen, 255)) : 8'($urandom_range(0, 255));
            end

            frame_q.delete();
            if (ep_kind == EP_NOISE) begin
               pick = $urandom_range(1, 12);
               repeat (pick) begin
                  if ($urandom_range(0, 2) == 0) frame_q.push_back(flag_reg);
                  else frame_q.push_back(8'($urandom_range(0, 255)));
               end
            end else begin
               frame_q.push_back(flag_reg);
               if (ep_kind == EP_BAD_CHECK)
                  frame_q.push_back(flag_reg ^ hi ^ lo ^ 8'($urandom_range(1, 255)));
               else
                  frame_q.push_back(flag_reg ^ hi ^ lo);
               frame_q.push_back(hi);
               frame_q.push_back(lo);
               if (ep_kind == EP_GOOD)
                  repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
            end

            for (i = 0; i < frame_q.size(); i++) begin
               send_byte(frame_q[i], RK_PRED, 8'h00, 1'b0);
               if (ep_kind != EP_NOISE) frame_bytes++;
            end
            ep++;
         end
      end

      drain_results(16);
      $display("Run covered %0d input bytes (%0d in directed rows and frame episodes).",
               bytes_in, frame_bytes);
      $display("Checked %0d body beats in %0d complete frames over %0d start flag settings.",
               beats_seen, frames_seen, flag_writes);
      if (mismatches == 0) begin
         $display("flagged_frame_receive_parser: match");
      end else begin
         $display("flagged_frame_receive_parser: mismatch");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run
   initial begin : watchdog
      #12_000_000;
      $display("Timeout with %0d body beats still expected.", expected_beats.size());
      $display("flagged_frame_receive_parser: mismatch");
      $finish;
   end

endmodule
